### src/vertical_fir_image_filter_macros.svh
// Assertion shorthands used by the filter top module.
// Each expects i_clk and i_rst_n in the scope where it is used.
`ifndef VERTICAL_FIR_IMAGE_FILTER_MACROS_SVH
`define VERTICAL_FIR_IMAGE_FILTER_MACROS_SVH

// Same-cycle implication.
`define VFIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VFIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/vfir_pkg.sv
`timescale 1ns / 1ps

package vfir_pkg;

    localparam int unsigned SAMPLE_BITS   = 16;
    localparam int unsigned COEF_BITS     = 16;
    localparam int unsigned COEF_FRAC     = 14;
    localparam int unsigned PROD_W        = SAMPLE_BITS + COEF_BITS;
    localparam int unsigned MAX_WIDTH     = 1024;
    localparam int unsigned COL_W         = $clog2(MAX_WIDTH);
    localparam int unsigned WIDTH_W       = 11;
    localparam int unsigned TAP_CNT_W     = 5;
    localparam int unsigned DEF_MAX_TAPS  = 16;
    localparam int unsigned CFG_DATA_W    = 64;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned NUM_COEF_REGS = 4;
    localparam int unsigned NUM_COEF      = NUM_COEF_REGS * (CFG_DATA_W / COEF_BITS);
    localparam int unsigned COEF_IDX_W    = $clog2(NUM_COEF);
    localparam int unsigned COEF_FLAT_W   = NUM_COEF * COEF_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TAP_COUNT = 3'd0,
        CFG_ROW_WIDTH = 3'd1,
        CFG_COEF_0_3  = 3'd2,
        CFG_COEF_4_7  = 3'd3,
        CFG_COEF_8_11 = 3'd4,
        CFG_COEF_12_15 = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel_in;
        logic                          frame_start;
        logic                          frame_end;
    } t_pix_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] pixel_out;
        logic [COL_W-1:0]              out_column;
        logic                          last_of_frame;
    } t_pix_out;

    // Control shared by every line-store cell.
    typedef struct packed {
        logic             adv;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [COL_W-1:0] rd_addr;
    } t_line_ctrl;

    // Pick one Q2.14 coefficient; taps with no register read as zero.
    function automatic logic signed [COEF_BITS-1:0] coef_pick(
        input logic [COEF_FLAT_W-1:0] flat,
        input logic [TAP_CNT_W-1:0]   idx
    );
        if (idx >= TAP_CNT_W'(NUM_COEF)) begin
            return '0;
        end
        return flat[idx[COEF_IDX_W-1:0] * COEF_BITS +: COEF_BITS];
    endfunction

endpackage

### src/vertical_fir_image_filter.sv
`timescale 1ns / 1ps
// A request passes the line-store read, multiply, adder tree levels and round/saturate.
// Throughput: one pixel per cycle while the output is not stalled;
//   the line stores take one read and one write per cycle.
// Reset (i_rst_n low, synchronous): clears counts, pipeline valids and config to defaults.
// Line stores are not cleared and need no clearing pass; they are read only once written.

`include "vertical_fir_image_filter_macros.svh"

module vertical_fir_image_filter import vfir_pkg::*; #(
    parameter int unsigned MAX_TAPS = DEF_MAX_TAPS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // source pixel channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_pix_in               i_in_data,
    // result pixel channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_pix_out              o_out_data
);

    localparam int unsigned LVLS    = $clog2(MAX_TAPS);
    localparam int unsigned ACC_W   = PROD_W + LVLS + 1;
    localparam int unsigned TAP_LIM = (MAX_TAPS < 31) ? MAX_TAPS : 31;
    localparam logic [TAP_CNT_W-1:0]  TAP_LIM_V   = TAP_CNT_W'(TAP_LIM);
    localparam logic [WIDTH_W-1:0]    WIDTH_MAX_V = WIDTH_W'(MAX_WIDTH);
    localparam logic signed [ACC_W-1:0] ROUND_V = ACC_W'(1 << (COEF_FRAC - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI  = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO  = ACC_W'(-(1 << (SAMPLE_BITS - 1)));

    // Request held between the line-store read and the multiply.
    typedef struct packed {
        logic                          valid;
        logic                          prod;
        logic                          last;
        logic [COL_W-1:0]              col;
        logic signed [SAMPLE_BITS-1:0] x;
    } t_s1;

    // Side band that travels alongside the adder tree.
    typedef struct packed {
        logic             prod;
        logic             last;
        logic [COL_W-1:0] col;
    } t_side;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [TAP_CNT_W-1:0]  r_tap_count;
    logic [WIDTH_W-1:0]    r_row_width;
    logic [CFG_DATA_W-1:0] r_coef [0:NUM_COEF_REGS-1];
    logic [COEF_FLAT_W-1:0] coef_flat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_CNT_W'(1);
            r_row_width <= WIDTH_W'(MAX_WIDTH);
            r_coef[0]   <= CFG_DATA_W'(1 << COEF_FRAC);
            for (int i = 1; i < NUM_COEF_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TAP_COUNT:  r_tap_count <= i_cfg_data[TAP_CNT_W-1:0];
                CFG_ROW_WIDTH:  r_row_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_COEF_0_3:   r_coef[0]   <= i_cfg_data;
                CFG_COEF_4_7:   r_coef[1]   <= i_cfg_data;
                CFG_COEF_8_11:  r_coef[2]   <= i_cfg_data;
                CFG_COEF_12_15: r_coef[3]   <= i_cfg_data;
                default: ; // drop writes to unused indexes
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_COEF_REGS; i++) begin
            coef_flat[i * CFG_DATA_W +: CFG_DATA_W] = r_coef[i];
        end
    end

    // ---------------------------------------------------------------------
    // Raster position and handshake
    // ---------------------------------------------------------------------
    logic [TAP_CNT_W-1:0] taps_eff;
    logic [WIDTH_W-1:0]   width_eff;
    logic [COL_W-1:0]     r_col, n_col, col_use;
    logic [TAP_CNT_W-1:0] r_rows, n_rows, rows_use;
    logic [WIDTH_W-1:0]   col_plus;
    logic                 produce;
    logic                 adv;
    logic                 in_acc;
    logic                 r_out_valid;
    t_pix_out             r_out;
    t_s1                  r1;
    t_side                r_side [0:LVLS];
    t_line_ctrl           line_ctrl;

    // The whole pipeline moves together; it halts only when a finished
    // result waits at the output and the far side is stalling.
    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = !adv;
    assign in_acc     = i_in_valid && adv;

    always_comb begin
        // clamp the tap count and row width to what the hardware holds
        if (r_tap_count == '0) begin
            taps_eff = TAP_CNT_W'(1);
        end else if (r_tap_count > TAP_LIM_V) begin
            taps_eff = TAP_LIM_V;
        end else begin
            taps_eff = r_tap_count;
        end
        if (r_row_width == '0) begin
            width_eff = WIDTH_W'(1);
        end else if (r_row_width > WIDTH_MAX_V) begin
            width_eff = WIDTH_MAX_V;
        end else begin
            width_eff = r_row_width;
        end

        // frame start restarts the counts before this pixel is placed
        col_use  = i_in_data.frame_start ? '0 : r_col;
        rows_use = i_in_data.frame_start ? '0 : r_rows;
        produce  = rows_use >= (taps_eff - TAP_CNT_W'(1));
        col_plus = WIDTH_W'(col_use) + WIDTH_W'(1);

        priority if (i_in_data.frame_end) begin
            n_col  = '0;
            n_rows = '0;
        end else if (col_plus >= width_eff) begin
            // end of row: also covers a column beyond a shrunk row width
            n_col  = '0;
            n_rows = (rows_use < TAP_LIM_V) ? rows_use + TAP_CNT_W'(1) : rows_use;
        end else begin
            n_col  = col_plus[COL_W-1:0];
            n_rows = rows_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_rows <= '0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_rows <= n_rows;
        end
    end

    // ---------------------------------------------------------------------
    // Line-store chain
    // ---------------------------------------------------------------------
    // Every request reads its column from all cells at acceptance; when the
    // pipeline next advances, each cell writes back what its upstream neighbour
    // held, so the window shifts down by one row in that column.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1 <= '0;
        end else if (adv) begin
            r1.valid <= in_acc;
            r1.prod  <= in_acc && produce;
            r1.last  <= i_in_data.frame_end;
            r1.col   <= col_use;
            r1.x     <= i_in_data.pixel_in;
        end
    end

    always_comb begin
        line_ctrl.adv     = adv;
        line_ctrl.wr_en   = adv && r1.valid;
        line_ctrl.wr_addr = r1.col;
        line_ctrl.rd_addr = col_use;
    end

    logic signed [SAMPLE_BITS-1:0] line_v [0:MAX_TAPS-1];
    logic signed [PROD_W-1:0]      leaves [0:MAX_TAPS-1];
    logic signed [PROD_W-1:0]      r_xprod;
    logic signed [COEF_BITS-1:0]   coef_x;

    assign line_v[0] = r1.x;
    assign leaves[0] = r_xprod;

    // The newest pixel always pairs with the last tap in use.
    assign coef_x = coef_pick(coef_flat, taps_eff - TAP_CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_xprod <= PROD_W'(r1.x * coef_x);
        end
    end

    generate
        for (genvar k = 0; k < MAX_TAPS - 1; k++) begin : g_cell
            vfir_cell #(
                .TAP_IDX (k + 1)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (line_ctrl),
                .i_shift (line_v[k]),
                .i_taps  (taps_eff),
                .i_coefs (coef_flat),
                .o_line  (line_v[k + 1]),
                .o_prod  (leaves[k + 1])
            );
        end
    endgenerate

    // ---------------------------------------------------------------------
    // Sum, round and saturate
    // ---------------------------------------------------------------------
    logic signed [ACC_W-1:0] root;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;
    logic signed [SAMPLE_BITS-1:0] sat;

    vfir_tree #(
        .MAX_TAPS (MAX_TAPS),
        .ACC_W    (ACC_W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_adv  (adv),
        .i_leaf (leaves),
        .o_root (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= LVLS; i++) begin
                r_side[i] <= '0;
            end
        end else if (adv) begin
            r_side[0] <= '{prod: r1.prod, last: r1.last, col: r1.col};
            for (int i = 1; i <= LVLS; i++) begin
                r_side[i] <= r_side[i - 1];
            end
        end
    end

    // Round half up, then floor-shift and clamp to the sample range.
    always_comb begin
        rounded = root + ROUND_V;
        shifted = rounded >>> COEF_FRAC;
        if (shifted > SAT_HI) begin
            sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            sat = shifted[SAMPLE_BITS-1:0];
        end
    end

    // Output register: parts the pipeline from the consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_side[LVLS].prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.pixel_out     <= sat;
            r_out.out_column    <= r_side[LVLS].col;
            r_out.last_of_frame <= r_side[LVLS].last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `VFIR_ASSERT_NEXT(a_end_restarts, in_acc && i_in_data.frame_end, r_col == '0 && r_rows == '0, "frame end did not restart the counts")
    `VFIR_ASSERT_NOW(a_rows_bounded, 1'b1, r_rows <= TAP_LIM_V, "row count beyond its limit")
    `VFIR_ASSERT_NOW(a_out_from_pipe, $rose(o_out_valid), $past(r_side[LVLS].prod), "result without a producing request")

endmodule

### src/vfir_cell.sv
`timescale 1ns / 1ps

// One line of the vertical window: a row store plus the multiply for its tap.
module vfir_cell import vfir_pkg::*; #(
    parameter int unsigned TAP_IDX = 1
) (
    input  logic                          i_clk,
    input  t_line_ctrl                    i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0] i_shift,
    input  logic [TAP_CNT_W-1:0]          i_taps,
    input  logic [COEF_FLAT_W-1:0]        i_coefs,
    output logic signed [SAMPLE_BITS-1:0] o_line,
    output logic signed [PROD_W-1:0]      o_prod
);

    localparam bit                   REACH = (TAP_IDX < 31);
    localparam logic [TAP_CNT_W-1:0] IDX_V = TAP_CNT_W'(TAP_IDX);

    logic signed [SAMPLE_BITS-1:0] r_mem [0:MAX_WIDTH-1];
    logic signed [SAMPLE_BITS-1:0] r_rd;
    logic signed [SAMPLE_BITS-1:0] r_fwd;
    logic                          r_hit;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [PROD_W-1:0]      n_prod;
    logic signed [COEF_BITS-1:0]   coef;
    logic                          use_tap;

    // Bypass the store when the previous request wrote the column read now.
    assign o_line = r_hit ? r_fwd : r_rd;

    always_comb begin
        use_tap = REACH && (i_taps > IDX_V);
        coef    = coef_pick(i_coefs, i_taps - IDX_V - TAP_CNT_W'(1));
        n_prod  = use_tap ? PROD_W'(o_line * coef) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.adv) begin
            r_rd   <= r_mem[i_ctrl.rd_addr];
            r_hit  <= i_ctrl.wr_en && (i_ctrl.wr_addr == i_ctrl.rd_addr);
            r_fwd  <= i_shift;
            r_prod <= n_prod;
        end
        if (i_ctrl.wr_en) begin
            r_mem[i_ctrl.wr_addr] <= i_shift;
        end
    end

    assign o_prod = r_prod;

endmodule

### src/vfir_tree.sv
`timescale 1ns / 1ps

// Registered binary adder tree, one level per cycle while i_adv is high; a single leaf passes through unregistered.
module vfir_tree import vfir_pkg::*; #(
    parameter int unsigned MAX_TAPS = DEF_MAX_TAPS,
    parameter int unsigned ACC_W    = PROD_W + $clog2(DEF_MAX_TAPS) + 1
) (
    input  logic                     i_clk,
    input  logic                     i_adv,
    input  logic signed [PROD_W-1:0] i_leaf [0:MAX_TAPS-1],
    output logic signed [ACC_W-1:0]  o_root
);

    localparam int unsigned LVLS = $clog2(MAX_TAPS);
    localparam int unsigned P    = 1 << LVLS;

    generate
        if (LVLS == 0) begin : g_single
            assign o_root = ACC_W'(i_leaf[0]);
        end else begin : g_tree
            logic signed [ACC_W-1:0] r_node [0:P-2];
            logic signed [ACC_W-1:0] n_node [0:P-2];
            logic signed [ACC_W-1:0] all_v  [0:2*P-2];

            // Heap order: inner nodes first, then the leaves, padded with zero.
            always_comb begin
                for (int i = 0; i < 2 * P - 1; i++) begin
                    if (i < P - 1) begin
                        all_v[i] = r_node[i];
                    end else if (i - (P - 1) < MAX_TAPS) begin
                        all_v[i] = ACC_W'(i_leaf[i - (P - 1)]);
                    end else begin
                        all_v[i] = '0;
                    end
                end
            end

            always_comb begin
                for (int i = 0; i < P - 1; i++) begin
                    n_node[i] = all_v[2 * i + 1] + all_v[2 * i + 2];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_node <= n_node;
                end
            end

            assign o_root = r_node[0];
        end
    endgenerate

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

// Scoreboard: tracks the filter's own state (registers, line stores and the
// raster counts) and keeps the results still due, oldest first.
class column_fir_checker;
    logic [vfir_pkg::TAP_CNT_W-1:0]  tap_reg;
    logic [vfir_pkg::WIDTH_W-1:0]    width_reg;
    logic [vfir_pkg::CFG_DATA_W-1:0] coef_bank [vfir_pkg::NUM_COEF_REGS];
    logic signed [15:0] rows_above [vfir_pkg::DEF_MAX_TAPS][vfir_pkg::MAX_WIDTH];
    int unsigned next_col;
    int unsigned rows_done;
    vfir_pkg::t_pix_out expected_pixels [$];
    int unsigned failures;

    function new();
        tap_reg      = 5'd1;
        width_reg    = 11'd1024;
        coef_bank[0] = 64'd16384;
        coef_bank[1] = '0;
        coef_bank[2] = '0;
        coef_bank[3] = '0;
        next_col     = 0;
        rows_done    = 0;
        failures     = 0;
    endfunction

    function void take_register(vfir_pkg::t_cfg_idx idx, logic [63:0] value);
        case (idx)
            vfir_pkg::CFG_TAP_COUNT:  tap_reg      = value[4:0];
            vfir_pkg::CFG_ROW_WIDTH:  width_reg    = value[10:0];
            vfir_pkg::CFG_COEF_0_3:   coef_bank[0] = value;
            vfir_pkg::CFG_COEF_4_7:   coef_bank[1] = value;
            vfir_pkg::CFG_COEF_8_11:  coef_bank[2] = value;
            vfir_pkg::CFG_COEF_12_15: coef_bank[3] = value;
            default: ;
        endcase
    endfunction

    function longint tap_weight(int unsigned t);
        logic [15:0] raw;
        if (t >= vfir_pkg::NUM_COEF) return 0;
        raw = coef_bank[t / 4][(t % 4) * 16 +: 16];
        return longint'($signed(raw));
    endfunction

    // Work out the result (if any) of one source pixel and advance the state.
    function void note_request(vfir_pkg::t_pix_in req);
        int unsigned taps, width, col, t, k;
        longint acc, res;
        vfir_pkg::t_pix_out exp_pix;
        taps  = (tap_reg == 0) ? 1 : ((tap_reg > 16) ? 16 : tap_reg);
        width = (width_reg == 0) ? 1 : ((width_reg > 1024) ? 1024 : width_reg);
        if (req.frame_start) begin
            next_col  = 0;
            rows_done = 0;
        end
        col = next_col % vfir_pkg::MAX_WIDTH;
        if (rows_done >= taps - 1) begin
            acc = tap_weight(taps - 1) * longint'($signed(req.pixel_in));
            for (t = 0; t + 1 < taps; t++) begin
                acc += tap_weight(t) * longint'(rows_above[taps - 2 - t][col]);
            end
            res = (acc + 64'sd8192) >>> 14;
            if (res > 32767) res = 32767;
            if (res < -32768) res = -32768;
            exp_pix.pixel_out     = res[15:0];
            exp_pix.out_column    = col[9:0];
            exp_pix.last_of_frame = req.frame_end;
            expected_pixels.push_back(exp_pix);
        end
        for (k = vfir_pkg::DEF_MAX_TAPS - 1; k > 0; k--) begin
            rows_above[k][col] = rows_above[k - 1][col];
        end
        rows_above[0][col] = req.pixel_in;
        if (col + 1 >= width) begin
            next_col = 0;
            if (rows_done < vfir_pkg::DEF_MAX_TAPS) rows_done++;
        end else begin
            next_col = col + 1;
        end
        if (req.frame_end) begin
            next_col  = 0;
            rows_done = 0;
        end
    endfunction

    function void check_pixel(vfir_pkg::t_pix_out got);
        vfir_pkg::t_pix_out want;
        if (expected_pixels.size() == 0) begin
            failures++;
            if (failures <= 10) begin
                $display("unexpected result: pixel %0d column %0d last %0b",
                         got.pixel_out, got.out_column, got.last_of_frame);
            end
            return;
        end
        want = expected_pixels.pop_front();
        if (got.pixel_out !== want.pixel_out || got.out_column !== want.out_column ||
            got.last_of_frame !== want.last_of_frame) begin
            failures++;
            if (failures <= 10) begin
                $display("result mismatch: expected %0d col %0d last %0b, got %0d col %0d last %0b",
                         want.pixel_out, want.out_column, want.last_of_frame,
                         got.pixel_out, got.out_column, got.last_of_frame);
            end
        end
    endfunction

    function int unsigned outstanding();
        return expected_pixels.size();
    endfunction
endclass

module tb;
    import vfir_pkg::*;

    localparam int unsigned QUIET_LIMIT  = 1000; // cycles with no request moved
    localparam int unsigned DRAIN_CYCLES = 16;   // extra wait after the last result for the pipeline to empty
    localparam int unsigned STIM_ITEMS   = 770;  // before the full-width row

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_pix_in               i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_pix_out              o_out_data;

    // steady: hold both sides busy (no gaps, no stalls) for a stretch
    bit                    steady       = 1'b0;
    int unsigned           sent         = 0;
    int unsigned           quiet_cycles = 0;
    column_fir_checker     fir_check;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vertical_fir_image_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Stall the result side now and then, except in the steady stretch.
    always @(negedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(99) < 11);
    end

    // Check each result as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            fir_check.check_pixel(o_out_data);
        end
    end

    // Watchdog: abandon the run if nothing moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Write one register; the block must be idle.
    task automatic write_register(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        fir_check.take_register(idx, value);
    endtask

    task automatic apply_setting(logic [4:0] taps_reg, logic [10:0] width_reg,
                                 logic [63:0] w0, logic [63:0] w1,
                                 logic [63:0] w2, logic [63:0] w3);
        write_register(CFG_TAP_COUNT, CFG_DATA_W'(taps_reg));
        write_register(CFG_ROW_WIDTH, CFG_DATA_W'(width_reg));
        write_register(CFG_COEF_0_3, w0);
        write_register(CFG_COEF_4_7, w1);
        write_register(CFG_COEF_8_11, w2);
        write_register(CFG_COEF_12_15, w3);
    endtask

    // Offer one pixel, with a random gap first, and hold it until taken.
    task automatic push_pixel(logic signed [15:0] value, bit first, bit last);
        t_pix_in req;
        req.pixel_in    = value;
        req.frame_start = first;
        req.frame_end   = last;
        steady = (sent >= 300 && sent < 700);
        while (!steady && $urandom_range(99) < 11) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        fir_check.note_request(req);
        sent++;
    endtask

    // Drop valid, let every result arrive, then let the pipeline empty out
    // (frame ends with too few rows leave work in flight with no result).
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (fir_check.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(15))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return 16'($urandom());
        endcase
    endfunction

    // Four Q2.14 taps: full range, gentle (rarely saturates) or corner values.
    function automatic logic [63:0] random_coefs(int unsigned style);
        logic [63:0] word;
        logic [15:0] w;
        int unsigned k;
        word = '0;
        for (k = 0; k < 4; k++) begin
            case (style)
                0: w = 16'($urandom());
                1: w = 16'($urandom_range(0, 4095)) - 16'd2048;
                default: begin
                    case ($urandom_range(3))
                        0:       w = 16'h8000;
                        1:       w = 16'h7FFF;
                        2:       w = 16'h4000;
                        default: w = 16'h0001;
                    endcase
                end
            endcase
            word[k * 16 +: 16] = w;
        end
        return word;
    endfunction

    // One frame of the given length; noisy frames get the odd stray
    // frame start or early frame end.
    task automatic send_frame(int unsigned pixels, bit noisy);
        int unsigned n;
        bit first, last;
        for (n = 0; n < pixels; n++) begin
            if (n == 0) first = ($urandom_range(3) != 0);
            else first = noisy && ($urandom_range(149) == 0);
            last = (n == pixels - 1) || (noisy && $urandom_range(149) == 0);
            push_pixel(random_sample(), first, last);
        end
    endtask

    // A random setting, then one or two frames deep enough to give results.
    task automatic random_phase(bit over_taps);
        logic [4:0]  taps_reg;
        logic [10:0] width_reg;
        int unsigned taps, width, cap, rows, f, frames, style;
        case ($urandom_range(9))
            0:       width_reg = 11'd0;
            1:       width_reg = 11'($urandom_range(17, 96));
            default: width_reg = 11'($urandom_range(1, 16));
        endcase
        if (over_taps) width_reg = 11'($urandom_range(1, 4));
        width = (width_reg == 0) ? 1 : width_reg;
        cap = 120 / width;
        if (cap < 1) cap = 1;
        if (cap > 16) cap = 16;
        if (over_taps) taps_reg = 5'($urandom_range(17, 31));
        else taps_reg = 5'($urandom_range(0, cap));
        taps = (taps_reg == 0) ? 1 : ((taps_reg > 16) ? 16 : taps_reg);
        style = $urandom_range(2);
        apply_setting(taps_reg, width_reg, random_coefs(style), random_coefs(style),
                      random_coefs(style), random_coefs(style));
        frames = $urandom_range(1, 2);
        for (f = 0; f < frames; f++) begin
            rows = taps - 1 + $urandom_range(1, 3);
            if (width <= 3) rows += $urandom_range(0, 12);
            send_frame(width * rows, 1'b1);
        end
        settle();
    endtask

    initial begin
        fir_check = new();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: one tap of 1.0, so each pixel comes straight back.
        push_pixel(16'sh7FFF, 1'b1, 1'b0);
        push_pixel(16'sh8000, 1'b0, 1'b0);
        push_pixel(16'sh0000, 1'b0, 1'b0);
        push_pixel(16'shFFFF, 1'b0, 1'b1);
        settle();

        // Zero tap count and zero width both act as one; tap of -2.0 saturates.
        apply_setting(5'd0, 11'd0, 64'h7FFF_4000_0001_8000, '1, '1, '1);
        push_pixel(16'sh8000, 1'b1, 1'b0);
        push_pixel(16'sh7FFF, 1'b0, 1'b0);
        push_pixel(16'sh0001, 1'b0, 1'b1);
        settle();

        // Smallest tap weight: rounding half up on either sign; start and end
        // marked on the same pixel last.
        write_register(CFG_COEF_0_3, 64'h0000_0000_0000_0001);
        push_pixel(16'sh2000, 1'b1, 1'b0);
        push_pixel(-16'sh2000, 1'b0, 1'b0);
        push_pixel(-16'sh2001, 1'b1, 1'b1);
        settle();

        // Shrink the row under a frame in flight: the pixel beyond the new
        // width keeps its column and closes the row.
        apply_setting(5'd1, 11'd8, 64'h0000_0000_0000_4000, '0, '0, '0);
        push_pixel(16'sh0011, 1'b1, 1'b0);
        push_pixel(16'sh0022, 1'b0, 1'b0);
        push_pixel(16'sh0033, 1'b0, 1'b0);
        push_pixel(16'sh0044, 1'b0, 1'b0);
        push_pixel(16'sh0055, 1'b0, 1'b0);
        settle();
        write_register(CFG_ROW_WIDTH, CFG_DATA_W'(2));
        push_pixel(16'sh0066, 1'b0, 1'b0);
        push_pixel(16'sh0077, 1'b0, 1'b0);
        push_pixel(16'sh0088, 1'b0, 1'b1);
        settle();

        // Three taps over two columns: a frame restarted mid-row and ended
        // before enough rows gives nothing; the next one saturates both ways.
        apply_setting(5'd3, 11'd2, 64'h0000_7FFF_7FFF_7FFF, '0, '0, '0);
        push_pixel(16'sh1234, 1'b1, 1'b0);
        push_pixel(16'sh4321, 1'b1, 1'b0);
        push_pixel(-16'sh1234, 1'b0, 1'b0);
        push_pixel(-16'sh4321, 1'b0, 1'b1);
        push_pixel(16'sh7FFF, 1'b1, 1'b0);
        push_pixel(16'sh8000, 1'b0, 1'b0);
        push_pixel(16'sh7FFF, 1'b0, 1'b0);
        push_pixel(16'sh8000, 1'b0, 1'b0);
        push_pixel(16'sh7FFF, 1'b0, 1'b0);
        push_pixel(16'sh8000, 1'b0, 1'b1);
        settle();

        // Random settings; the first one asks for more taps than exist.
        random_phase(1'b1);
        while (sent < STIM_ITEMS) random_phase(1'b0);

        // Widest row: a width register past the limit wraps at 1024 columns.
        apply_setting(5'd0, 11'($urandom_range(1025, 2047)), random_coefs(2),
                      random_coefs(0), random_coefs(0), random_coefs(0));
        send_frame(1028, 1'b0);
        settle();

        if (fir_check.failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
